>>> src/assert_macros.svh
// Assertion helpers shared by the RTL. Every property is sampled on the
// rising edge of i_clk and is switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent sequence must start in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> src/plist_pkg.sv
// ----------------------------------------------------------------------------
// Positional list package
// Shared widths, status and action codes, cell control and transaction types.
// ----------------------------------------------------------------------------
package plist_pkg;

    localparam int unsigned DATA_W       = 32;
    localparam int unsigned POS_W        = 8;
    localparam int unsigned LEN_W        = 8;
    localparam int unsigned STAT_W       = 2;
    localparam int unsigned DEF_CAPACITY = 128;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LOWER,
        CELL_FROM_UPPER
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     tap_en;
    } t_cell_ctrl;

    typedef struct packed {
        logic                     action;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] removed_value;
        logic [LEN_W-1:0]         list_length;
    } t_result;

endpackage

>>> src/plist_cell.sv
// ----------------------------------------------------------------------------
// Positional list cell
// One list entry: holds, loads a new value or takes a neighbour's entry.
// ----------------------------------------------------------------------------
module plist_cell (
    input  logic                          i_clk,
    input  plist_pkg::t_cell_ctrl         i_ctrl,
    input  logic [plist_pkg::DATA_W-1:0]  i_value,
    input  logic [plist_pkg::DATA_W-1:0]  i_lower,
    input  logic [plist_pkg::DATA_W-1:0]  i_upper,
    output logic [plist_pkg::DATA_W-1:0]  o_data,
    output logic [plist_pkg::DATA_W-1:0]  o_tap
);
    import plist_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        case (i_ctrl.op)
            CELL_LOAD:       n_data = i_value;
            CELL_FROM_LOWER: n_data = i_lower;
            CELL_FROM_UPPER: n_data = i_upper;
            default:         n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // The entry is offered to the gather tree only when it is being removed.
    assign o_tap  = i_ctrl.tap_en ? r_data : '0;

endmodule

>>> src/plist_group.sv
// ----------------------------------------------------------------------------
// Positional list gather group
// Registered OR over the taps of one group of cells.
// ----------------------------------------------------------------------------
module plist_group #(
    parameter int unsigned GROUP = 16
) (
    input  logic                                     i_clk,
    input  logic [GROUP-1:0][plist_pkg::DATA_W-1:0]  i_taps,
    output logic [plist_pkg::DATA_W-1:0]             o_or
);
    import plist_pkg::*;

    logic [DATA_W-1:0] r_or;
    logic [DATA_W-1:0] n_or;

    always_comb begin
        n_or = '0;
        for (int i = 0; i < GROUP; i++) begin
            n_or = n_or | i_taps[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_or <= n_or;
    end

    assign o_or = r_or;

endmodule

>>> src/positional_list_insert_delete_top.sv
// ----------------------------------------------------------------------------
// Positional list insert and delete
// Ordered list of signed 32-bit entries held in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Usage. A command transaction is taken at a rising edge where start is high
// and busy is low. It carries an action (insert before, or delete at, a
// 1-based position), the position and, for an insert, the value.
// Each command produces exactly one result transaction on o_result, marked by
// o_done for a single cycle. The receiver cannot hold results off, so o_done
// must be sampled on the edge that ends that cycle.
// On acceptance the cells shift and the removed entry is gathered into group
// registers at the accept edge, and the groups are merged into the result
// register at the next edge.
// Throughput is one command per cycle; every cell moves in the accept cycle,
// so back-to-back commands see the list already updated.
// Reset clears the entry count and the pipeline; the entries themselves are
// not cleared, as positions at or beyond the length are never read. busy is
// high while reset is held and until r_ready is set after it is released.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_top #(
    parameter int unsigned CAPACITY = plist_pkg::DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  plist_pkg::t_cmd    i_cmd,
    output logic               o_done,
    output plist_pkg::t_result o_result
);
    import plist_pkg::*;
    `include "assert_macros.svh"

    // Index and count widths follow the capacity.
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    // Width for comparing the position against a cell index.
    localparam int unsigned XW = (IW > POS_W) ? IW : POS_W;
    // Width for comparing the position against the count, with room for +1.
    localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;
    // Cells are gathered in groups so that no OR stage grows too wide.
    localparam int unsigned GROUP  = (CAPACITY > 256) ? 64 : 16;
    localparam int unsigned NGROUP = (CAPACITY + GROUP - 1) / GROUP;

    logic                     r_ready;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_s1_valid;
    logic [STAT_W-1:0]        r_s1_status;
    logic [LEN_W-1:0]         r_s1_len;
    logic                     r_done;
    t_result                  r_result;
    logic [DATA_W-1:0]        n_removed;

    logic                     w_accept;
    logic                     w_pos_zero;
    logic [PW-1:0]            w_pos_x;
    logic [PW-1:0]            w_cnt_x;
    logic                     w_full;
    logic                     w_ins_ok;
    logic                     w_del_ok;
    logic [STAT_W-1:0]        w_status;
    logic [XW-1:0]            w_idx;
    logic                     w_bad_removed;

    logic [CAPACITY-1:0][DATA_W-1:0]      w_data;
    logic [NGROUP*GROUP-1:0][DATA_W-1:0]  w_taps;
    logic [NGROUP-1:0][DATA_W-1:0]        w_grp;

    // ------------------------------------------------------------------
    // Command decode. Position checks come before the full check.
    // ------------------------------------------------------------------
    always_comb begin
        w_accept   = start && r_ready;
        w_pos_zero = (i_cmd.position == '0);
        w_pos_x    = PW'(i_cmd.position);
        w_cnt_x    = PW'(r_count);
        w_full     = (r_count == CW'(CAPACITY));
        w_idx      = XW'(i_cmd.position) - XW'(1);
        w_ins_ok   = 1'b0;
        w_del_ok   = 1'b0;
        w_status   = ST_OK;
        n_count    = r_count;
        if (i_cmd.action == ACT_INSERT) begin
            if (w_pos_zero || (w_pos_x > w_cnt_x + PW'(1))) begin
                w_status = ST_BAD_POS;
            end else if (w_full) begin
                w_status = ST_FULL;
            end else begin
                w_ins_ok = w_accept;
            end
        end else begin
            if (w_pos_zero || (w_pos_x > w_cnt_x)) begin
                w_status = ST_BAD_POS;
            end else begin
                w_del_ok = w_accept;
            end
        end
        if (w_ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (w_del_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    // ------------------------------------------------------------------
    // The chain of cells. Every cell decides its own move from the index.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_W-1:0] w_lower;
        logic [DATA_W-1:0] w_upper;
        logic              w_eq;
        logic              w_gt;
        t_cell_ctrl        w_ctrl;

        if (k == 0) begin : g_first
            assign w_lower = i_cmd.value;
        end else begin : g_lower
            assign w_lower = w_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_upper = i_cmd.value;
        end else begin : g_upper
            assign w_upper = w_data[k+1];
        end

        always_comb begin
            w_eq          = (w_idx == XW'(k));
            w_gt          = (w_idx < XW'(k));
            w_ctrl.tap_en = w_del_ok && w_eq;
            if (w_ins_ok) begin
                w_ctrl.op = w_gt ? CELL_FROM_LOWER : (w_eq ? CELL_LOAD : CELL_HOLD);
            end else if (w_del_ok) begin
                w_ctrl.op = (w_gt || w_eq) ? CELL_FROM_UPPER : CELL_HOLD;
            end else begin
                w_ctrl.op = CELL_HOLD;
            end
        end

        plist_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_value (i_cmd.value),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_data  (w_data[k]),
            .o_tap   (w_taps[k])
        );
    end

    // Unused tap slots of the last group read as zero.
    for (genvar k = CAPACITY; k < NGROUP * GROUP; k++) begin : g_pad
        assign w_taps[k] = '0;
    end

    // ------------------------------------------------------------------
    // Gather tree for the removed entry: registered groups, then a merge.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NGROUP; g++) begin : g_group
        plist_group #(
            .GROUP (GROUP)
        ) u_group (
            .i_clk  (i_clk),
            .i_taps (w_taps[g*GROUP +: GROUP]),
            .o_or   (w_grp[g])
        );
    end

    always_comb begin
        n_removed = '0;
        for (int g = 0; g < NGROUP; g++) begin
            n_removed = n_removed | w_grp[g];
        end
    end

    // ------------------------------------------------------------------
    // Control and result registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready    <= 1'b0;
            r_count    <= '0;
            r_s1_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_ready    <= 1'b1;
            r_count    <= n_count;
            r_s1_valid <= w_accept;
            r_done     <= r_s1_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_s1_status            <= w_status;
        r_s1_len               <= LEN_W'(n_count);
        r_result.status        <= r_s1_status;
        r_result.list_length   <= r_s1_len;
        r_result.removed_value <= n_removed;
    end

    assign busy     = !r_ready;
    assign o_done   = r_done;
    assign o_result = r_result;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A failed command must never hand back a removed value.
    assign w_bad_removed = o_done && (o_result.status != ST_OK)
                           && (o_result.removed_value != '0);

    `ASSERT_ALWAYS(a_count_bound, r_count <= CW'(CAPACITY), "entry count above capacity")
    `ASSERT_NEXT(a_result_follows, w_accept, ##1 o_done, "accepted command gave no result")
    `ASSERT_ALWAYS(a_removed_zero, !w_bad_removed, "failed command returned a value")

endmodule
